// ===== rtl/bitmap_font_binary_parser_top_defines.svh =====
// Assertion macros for the bitmap font binary parser.
// No dependencies; included by the RTL files that carry assertions.
`ifndef BITMAP_FONT_BINARY_PARSER_TOP_DEFINES_SVH
`define BITMAP_FONT_BINARY_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BMFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bmfp assertion failed");
`define BMFP_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bmfp assertion failed");
`else
`define BMFP_ASSERT(lbl, clk, rst_n, prop)
`define BMFP_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== rtl/bmfp_pkg.sv =====
// Shared types, codes and constants of the bitmap font binary parser.
// No dependencies; imported by every module of the block.
package bmfp_pkg;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_BLOCK_ID = 3'd1;
    localparam logic [2:0] PH_SIZE     = 3'd2;
    localparam logic [2:0] PH_BODY     = 3'd3;
    localparam logic [2:0] PH_SKIP     = 3'd4;

    localparam logic [2:0] KIND_INFO   = 3'd0;
    localparam logic [2:0] KIND_COMMON = 3'd1;
    localparam logic [2:0] KIND_GLYPH  = 3'd2;
    localparam logic [2:0] KIND_KERN   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [7:0] BLK_INFO   = 8'd1;
    localparam logic [7:0] BLK_COMMON = 8'd2;
    localparam logic [7:0] BLK_GLYPH  = 8'd4;
    localparam logic [7:0] BLK_KERN   = 8'd5;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
    localparam logic [2:0] ERR_PAGE_LARGE  = 3'd3;
    localparam logic [2:0] ERR_PAGES       = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

    localparam logic [7:0] MAGIC_0     = 8'h42;
    localparam logic [7:0] MAGIC_1     = 8'h4D;
    localparam logic [7:0] MAGIC_2     = 8'h46;
    localparam logic [7:0] VERSION     = 8'd3;
    localparam logic [1:0] HDR_LAST    = 2'd3;

    localparam int         BUF_LEN     = 20;
    localparam logic [4:0] GLYPH_LEN   = 5'd20;
    localparam logic [4:0] KERN_LEN    = 5'd10;
    localparam logic [15:0] ONE_PAGE   = 16'd1;
    localparam logic [15:0] MAX_TEX_RESET = 16'd4096;

    typedef struct packed {
        logic [2:0]         record_kind;
        logic [31:0]        ident;
        logic [31:0]        second_ident;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        width;
        logic [15:0]        height;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] advance;
        logic [31:0]        padding;
        logic [2:0]         error_code;
    } t_result;

    function automatic logic [7:0] header_byte(input logic [1:0] p);
        logic [7:0] v;
        case (p)
            2'd0:    v = MAGIC_0;
            2'd1:    v = MAGIC_1;
            2'd2:    v = MAGIC_2;
            default: v = VERSION;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/bmfp_parser.sv =====
// Parse state, entry buffer and record decode for one byte per cycle while i_adv is high.
// Depends on bmfp_pkg and bitmap_font_binary_parser_top_defines.svh.
`include "bitmap_font_binary_parser_top_defines.svh"
module bmfp_parser
    import bmfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_byte,
    input  logic        i_fend,
    input  logic [15:0] i_max_tex,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_bp, n_bp;
    logic [7:0]  r_kind, n_kind;
    logic [31:0] r_rem, n_rem;
    logic [7:0]  r_buf [BUF_LEN];
    logic [7:0]  n_buf [BUF_LEN];
    logic [7:0]  v_buf [BUF_LEN];

    t_result     rec_info, rec_common, rec_glyph, rec_kern, res;
    logic        emit;
    logic [1:0]  p;
    logic [31:0] size_full;
    logic [4:0]  bp_inc;
    logic        is_hdr_blk;

    always_comb begin
        for (int i = 0; i < BUF_LEN; i++) begin
            if (r_phase == PH_SIZE) begin
                v_buf[i] = '0;
            end else if (r_phase == PH_BODY && r_bp == 5'(i)) begin
                v_buf[i] = i_byte;
            end else begin
                v_buf[i] = r_buf[i];
            end
        end
    end

    always_comb begin
        rec_info             = '0;
        rec_info.record_kind = KIND_INFO;
        rec_info.ident       = {16'b0, v_buf[1], v_buf[0]};
        rec_info.padding     = {v_buf[7], v_buf[8], v_buf[9], v_buf[10]};

        rec_common             = '0;
        rec_common.record_kind = KIND_COMMON;
        rec_common.ident       = {16'b0, v_buf[1], v_buf[0]};
        rec_common.pos_x       = {v_buf[9], v_buf[8]};
        rec_common.width       = {v_buf[5], v_buf[4]};
        rec_common.height      = {v_buf[7], v_buf[6]};
        if (rec_common.width > i_max_tex || rec_common.height > i_max_tex) begin
            rec_common.error_code = ERR_PAGE_LARGE;
        end else if (rec_common.pos_x != ONE_PAGE) begin
            rec_common.error_code = ERR_PAGES;
        end

        rec_glyph             = '0;
        rec_glyph.record_kind = KIND_GLYPH;
        rec_glyph.ident       = {v_buf[3], v_buf[2], v_buf[1], v_buf[0]};
        rec_glyph.pos_x       = {v_buf[5], v_buf[4]};
        rec_glyph.pos_y       = {v_buf[7], v_buf[6]};
        rec_glyph.width       = {v_buf[9], v_buf[8]};
        rec_glyph.height      = {v_buf[11], v_buf[10]};
        rec_glyph.offset_x    = {v_buf[13], v_buf[12]};
        rec_glyph.offset_y    = {v_buf[15], v_buf[14]};
        rec_glyph.advance     = {v_buf[17], v_buf[16]};

        rec_kern              = '0;
        rec_kern.record_kind  = KIND_KERN;
        rec_kern.ident        = {v_buf[3], v_buf[2], v_buf[1], v_buf[0]};
        rec_kern.second_ident = {v_buf[7], v_buf[6], v_buf[5], v_buf[4]};
        rec_kern.advance      = {v_buf[9], v_buf[8]};
    end

    assign p          = r_bp[1:0];
    assign is_hdr_blk = (r_kind == BLK_INFO) || (r_kind == BLK_COMMON);
    assign size_full  = r_rem | ({24'b0, i_byte} << {p, 3'b000});
    assign bp_inc     = (r_bp < GLYPH_LEN) ? r_bp + 5'd1 : r_bp;

    always_comb begin
        n_phase = r_phase;
        n_bp    = r_bp;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_buf   = r_buf;
        emit    = 1'b0;
        res     = '0;
        case (r_phase)
            PH_HEADER: begin
                if (i_byte != header_byte(p)) begin
                    emit             = 1'b1;
                    res.record_kind  = KIND_ERROR;
                    res.error_code   = (p == HDR_LAST) ? ERR_BAD_VERSION : ERR_BAD_MAGIC;
                    n_phase          = PH_SKIP;
                end else if (p == HDR_LAST) begin
                    n_phase = PH_BLOCK_ID;
                    n_bp    = '0;
                end else begin
                    n_bp = r_bp + 5'd1;
                end
            end
            PH_BLOCK_ID: begin
                n_kind  = i_byte;
                n_rem   = '0;
                n_bp    = '0;
                n_phase = PH_SIZE;
            end
            PH_SIZE: begin
                n_rem = size_full;
                if (p == HDR_LAST) begin
                    n_bp = '0;
                    for (int i = 0; i < BUF_LEN; i++) begin
                        n_buf[i] = '0;
                    end
                    if (size_full == '0) begin
                        if (is_hdr_blk) begin
                            emit = 1'b1;
                            res  = (r_kind == BLK_INFO) ? rec_info : rec_common;
                        end
                        n_phase = PH_BLOCK_ID;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else begin
                    n_bp = r_bp + 5'd1;
                end
            end
            PH_BODY: begin
                if (r_bp < GLYPH_LEN) begin
                    n_buf[r_bp] = i_byte;
                end
                n_bp = bp_inc;
                if (r_kind == BLK_GLYPH && bp_inc == GLYPH_LEN) begin
                    emit = 1'b1;
                    res  = rec_glyph;
                    n_bp = '0;
                end else if (r_kind == BLK_KERN && bp_inc == KERN_LEN) begin
                    emit = 1'b1;
                    res  = rec_kern;
                    n_bp = '0;
                end
                n_rem = r_rem - 32'd1;
                if (r_rem == 32'd1) begin
                    if (is_hdr_blk) begin
                        emit = 1'b1;
                        res  = (r_kind == BLK_INFO) ? rec_info : rec_common;
                    end
                    n_bp    = '0;
                    n_phase = PH_BLOCK_ID;
                end
            end
            default: begin
            end
        endcase
        if (i_fend) begin
            if (n_phase inside {PH_HEADER, PH_SIZE, PH_BODY}) begin
                if (!emit) begin
                    emit            = 1'b1;
                    res             = '0;
                    res.record_kind = KIND_ERROR;
                end
                res.error_code = ERR_TRUNCATED;
            end
            n_phase = PH_HEADER;
            n_bp    = '0;
            n_rem   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_bp    <= '0;
            r_kind  <= '0;
            r_rem   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_bp    <= n_bp;
            r_kind  <= n_kind;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_buf <= n_buf;
        end
    end

    assign o_res_valid = i_adv && emit;
    assign o_res       = res;

    `BMFP_ASSERT(a_body_rem_nonzero, i_clk, i_rst_n, (r_phase == PH_BODY) |-> (r_rem != '0))
    `BMFP_ASSERT(a_header_pos, i_clk, i_rst_n, (r_phase == PH_HEADER) |-> (r_bp < 5'd4))
    `BMFP_ASSERT(a_kern_pos, i_clk, i_rst_n,
        (r_phase == PH_BODY && r_kind == BLK_KERN) |-> (r_bp < KERN_LEN))
    `BMFP_ASSERT(a_error_coded, i_clk, i_rst_n,
        (o_res_valid && o_res.record_kind == KIND_ERROR) |-> (o_res.error_code != ERR_NONE))
    `BMFP_ASSERT_NR(a_reset_rearm, i_clk, !i_rst_n |=> (r_phase == PH_HEADER && r_bp == '0))

endmodule

// ===== rtl/bmfp_out_reg.sv =====
// Result register holding one record until the consumer takes it.
// Depends on bmfp_pkg.
module bmfp_out_reg
    import bmfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/bitmap_font_binary_parser_top.sv =====
// Top level of the bitmap font binary parser: input register, limit register,
// parser and result register. Depends on bmfp_pkg, bmfp_parser, bmfp_out_reg.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | i_in_valid/o_in_ready, data, end     | in
//  result   | o_out_valid/i_out_ready, 12 fields   | out
//  config   | i_cfg_we, i_cfg_wdata (limit)        | in
//
// One beat per cycle while results are taken; records follow via the result register.
// Each byte updates the parse state between the input and result registers.
// Reset is synchronous: parser rearms for a header, limit returns to 4096.
// A stalled result holds the parser; the input register still takes one more beat.
module bitmap_font_binary_parser_top
    import bmfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_record_kind,
    output logic [31:0]        o_ident,
    output logic [31:0]        o_second_ident,
    output logic [15:0]        o_pos_x,
    output logic [15:0]        o_pos_y,
    output logic [15:0]        o_width,
    output logic [15:0]        o_height,
    output logic signed [15:0] o_offset_x,
    output logic signed [15:0] o_offset_y,
    output logic signed [15:0] o_advance,
    output logic [31:0]        o_padding,
    output logic [2:0]         o_error_code,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_fend;
    logic [15:0] r_max_tex;
    logic        adv;
    logic        in_take;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    assign adv        = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_tex  <= MAX_TEX_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_max_tex <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_fend <= i_frame_end;
        end
    end

    bmfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .i_fend      (r_in_fend),
        .i_max_tex   (r_max_tex),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bmfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_record_kind  = out_res.record_kind;
    assign o_ident        = out_res.ident;
    assign o_second_ident = out_res.second_ident;
    assign o_pos_x        = out_res.pos_x;
    assign o_pos_y        = out_res.pos_y;
    assign o_width        = out_res.width;
    assign o_height       = out_res.height;
    assign o_offset_x     = out_res.offset_x;
    assign o_offset_y     = out_res.offset_y;
    assign o_advance      = out_res.advance;
    assign o_padding      = out_res.padding;
    assign o_error_code   = out_res.error_code;

endmodule
